// ===== rtl/leb128_varint_codec_core_assert.svh =====
// ----------------------------------------------------------------------------
// leb128 codec assertion macros
// concurrent assertion shorthands used by the codec control module lvc_ctrl
// ----------------------------------------------------------------------------
`ifndef LEB128_VARINT_CODEC_CORE_ASSERT_SVH
`define LEB128_VARINT_CODEC_CORE_ASSERT_SVH

// same-cycle implication
`define LVC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LVC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lvc_pkg
// shared types and constants of the leb128 varint codec
// ----------------------------------------------------------------------------
package lvc_pkg;

   localparam int unsigned MAX_DECODE_BYTES = 9;
   localparam logic [3:0]  MAX_CNT          = 4'(MAX_DECODE_BYTES);
   localparam int unsigned GROUP_BITS       = 7;
   localparam int unsigned ACC_W            = 63;
   localparam int unsigned SR_W             = 64 - GROUP_BITS;

   typedef enum logic [0:0] {
      OP_DECODE = 1'b0,
      OP_ENCODE = 1'b1
   } opcode_type;

   typedef enum logic [0:0] {
      KIND_BYTE    = 1'b0,
      KIND_OUTCOME = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_SHORT   = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      ST_IDLE   = 1'b0,
      ST_ENCODE = 1'b1
   } state_type;

   typedef enum logic [1:0] {
      CMD_NONE      = 2'd0,
      CMD_DECODE    = 2'd1,
      CMD_ENC_FIRST = 2'd2,
      CMD_ENC_NEXT  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic dec_done;
      logic first_more;
      logic next_more;
   } dp_status_type;

endpackage

// ===== rtl/lvc_datapath.sv =====
// ----------------------------------------------------------------------------
// lvc_datapath
// decode accumulator, encode shift register, mode bit and result registers
// ----------------------------------------------------------------------------
module lvc_datapath
   import lvc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data,
   input  cmd_type       cmd,
   output dp_status_type status,
   input  logic [7:0]    req_data_byte,
   input  logic          req_buffer_last,
   input  logic [63:0]   req_value_in,
   output logic          rsp_result_kind,
   output logic [7:0]    rsp_out_byte,
   output logic [63:0]   rsp_decoded_value,
   output logic [3:0]    rsp_consumed_count,
   output logic [1:0]    rsp_status,
   output logic          rsp_last_of_run
);

   logic             zz_ff;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [SR_W-1:0]  sr_ff, sr_in;

   logic             kind_ff, kind_in;
   logic [7:0]       byte_ff, byte_in;
   logic [63:0]      value_ff, value_in;
   logic [3:0]       count_ff, count_in;
   logic [1:0]       stat_ff, stat_in;
   logic             last_ff, last_in;
   logic             load;

   logic             over;
   logic [5:0]       shamt;
   logic [ACC_W-1:0] acc_new;
   logic [3:0]       cnt_new;
   logic [63:0]      dec_val;
   logic [63:0]      zig;
   logic             first_more;
   logic             next_more;

   always_comb begin
      over    = cnt_ff >= MAX_CNT;
      shamt   = 6'({cnt_ff, 3'b000} - {3'b000, cnt_ff});
      acc_new = acc_ff | (ACC_W'(req_data_byte[6:0]) << shamt);
      cnt_new = cnt_ff + 4'd1;
      if (zz_ff) begin
         dec_val = {2'b00, acc_new[ACC_W-1:1]} ^ {64{acc_new[0]}};
      end else begin
         dec_val = {1'b0, acc_new};
      end
      if (zz_ff) begin
         zig = {req_value_in[62:0], 1'b0} ^ {64{req_value_in[63]}};
      end else begin
         zig = req_value_in;
      end
      first_more = |zig[63:GROUP_BITS];
      next_more  = |sr_ff[SR_W-1:GROUP_BITS];
   end

   assign status.dec_done   = over || !req_data_byte[7] || req_buffer_last;
   assign status.first_more = first_more;
   assign status.next_more  = next_more;

   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      sr_in    = sr_ff;
      load     = 1'b0;
      kind_in  = KIND_BYTE;
      byte_in  = 8'd0;
      value_in = 64'd0;
      count_in = 4'd0;
      stat_in  = STAT_OK;
      last_in  = 1'b0;
      unique case (cmd)
         CMD_DECODE: begin
            kind_in = KIND_OUTCOME;
            if (over) begin
               load     = 1'b1;
               stat_in  = STAT_INVALID;
               count_in = cnt_ff;
               acc_in   = '0;
               cnt_in   = 4'd0;
            end else if (!req_data_byte[7]) begin
               load     = 1'b1;
               stat_in  = STAT_OK;
               value_in = dec_val;
               count_in = cnt_new;
               acc_in   = '0;
               cnt_in   = 4'd0;
            end else if (req_buffer_last) begin
               load     = 1'b1;
               stat_in  = STAT_SHORT;
               count_in = cnt_new;
               acc_in   = '0;
               cnt_in   = 4'd0;
            end else begin
               acc_in = acc_new;
               cnt_in = cnt_new;
            end
         end
         CMD_ENC_FIRST: begin
            load    = 1'b1;
            byte_in = {first_more, zig[GROUP_BITS-1:0]};
            last_in = !first_more;
            sr_in   = zig[63:GROUP_BITS];
         end
         CMD_ENC_NEXT: begin
            load    = 1'b1;
            byte_in = {next_more, sr_ff[GROUP_BITS-1:0]};
            last_in = !next_more;
            sr_in   = SR_W'(sr_ff[SR_W-1:GROUP_BITS]);
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zz_ff  <= 1'b0;
         acc_ff <= '0;
         cnt_ff <= 4'd0;
      end else begin
         if (csr_wr_en) begin
            zz_ff <= csr_wr_data;
         end
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
      if (load) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         value_ff <= value_in;
         count_ff <= count_in;
         stat_ff  <= stat_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_result_kind    = kind_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_decoded_value  = value_ff;
   assign rsp_consumed_count = count_ff;
   assign rsp_status         = stat_ff;
   assign rsp_last_of_run    = last_ff;

endmodule

// ===== rtl/lvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lvc_ctrl
// handshake control and encode sequencing for the leb128 codec
// ----------------------------------------------------------------------------
`include "leb128_varint_codec_core_assert.svh"

module lvc_ctrl
   import lvc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_opcode,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output cmd_type       cmd,
   input  dp_status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      cmd          = CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               if (req_opcode == OP_ENCODE) begin
                  cmd          = CMD_ENC_FIRST;
                  rsp_valid_in = 1'b1;
                  if (status.first_more) begin
                     state_in = ST_ENCODE;
                  end
               end else begin
                  cmd = CMD_DECODE;
                  if (status.dec_done) begin
                     rsp_valid_in = 1'b1;
                  end
               end
            end
         end
         ST_ENCODE: begin
            if (out_free) begin
               cmd          = CMD_ENC_NEXT;
               rsp_valid_in = 1'b1;
               if (!status.next_more) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `LVC_ASSERT_IMP(a_encode_holds_req, clock, reset, state_ff == ST_ENCODE, req_stall, "item taken during encode run")
   `LVC_ASSERT_NXT(a_encode_emits, clock, reset, req_valid && !req_stall && req_opcode == OP_ENCODE, rsp_valid_ff, "encode item gave no byte")
   `LVC_ASSERT_NXT(a_run_ends, clock, reset, cmd == CMD_ENC_NEXT && !status.next_more, state_ff == ST_IDLE, "encode run did not end")

endmodule

// ===== rtl/leb128_varint_codec_core.sv =====
// ----------------------------------------------------------------------------
// leb128_varint_codec_core
// LEB128 varint codec with optional zigzag signed mapping. A decode item
// carries one byte; an outcome appears when a number ends, runs short or
// overruns. An encode item emits one byte per cycle from a shift register
// unless the output stalls, 1 to 10 bytes per value, and no new item is
// taken until its last byte is loaded. The registered result stage lets the
// next item in while a result waits, if that result is taken in the same cycle.
// ----------------------------------------------------------------------------
module leb128_varint_codec_core
   import lvc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_buffer_last,
   input  logic [63:0] req_value_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [63:0] rsp_decoded_value,
   output logic [3:0]  rsp_consumed_count,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_of_run
);

   cmd_type       cmd;
   dp_status_type status;

   lvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .status     (status)
   );

   lvc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .cmd                (cmd),
      .status             (status),
      .req_data_byte      (req_data_byte),
      .req_buffer_last    (req_buffer_last),
      .req_value_in       (req_value_in),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_decoded_value  (rsp_decoded_value),
      .rsp_consumed_count (rsp_consumed_count),
      .rsp_status         (rsp_status),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule
